@@ hw/rtl/sorted_priority_queue_assert.svh @@
// assertion macros for the sorted priority queue checker
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue assertion failed");

`endif

@@ hw/rtl/spq_pkg.sv @@
// types, codes and constants shared by the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int PRIO_W        = 16;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_HEAD    = 2'd1,
        OP_EXACT   = 2'd2,
        OP_ATLEAST = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_FIND,
        S_SHIFT
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_TOP,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        WA_ZERO,
        WA_UP,
        WA_DOWN
    } t_wr_addr;

    typedef enum logic {
        WS_NEW,
        WS_RDATA
    } t_wr_src;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        RS_ZERO,
        RS_HELD,
        RS_RDATA
    } t_res_src;

    typedef struct packed {
        logic     load_req;
        t_idx_op  idx_op;
        logic     wr_en;
        t_wr_addr wr_addr;
        t_wr_src  wr_src;
        t_cnt_op  cnt_op;
        logic     cap_data;
        logic     res_load;
        t_status  res_status;
        t_res_src res_src;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic idx_zero;
        logic idx_last;
        logic ins_shift;
        logic hit;
        logic out_free;
    } t_stat;

endpackage

@@ hw/rtl/spq_if.sv @@
// request and result channel interfaces of the sorted priority queue
`timescale 1ns / 1ps

interface spq_req_if;
    logic                              valid;
    logic                              ready;
    logic [spq_pkg::OP_W-1:0]          opcode;
    logic signed [spq_pkg::DATA_W-1:0] item_data;
    logic [spq_pkg::PRIO_W-1:0]        key_priority;

    modport source (output valid, output opcode, output item_data, output key_priority,
                    input ready);
    modport sink (input valid, input opcode, input item_data, input key_priority,
                  output ready);
endinterface

interface spq_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [spq_pkg::DATA_W-1:0] out_data;
    logic [spq_pkg::ST_W-1:0]          status;

    modport source (output valid, output out_data, output status, input ready);
    modport sink (input valid, input out_data, input status, output ready);
endinterface

@@ hw/rtl/spq_ram.sv @@
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/spq_ctrl.sv @@
// sequencer for insert, search and gap-closing shifts
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  spq_pkg::t_opcode i_req_opcode,
    input  spq_pkg::t_stat   i_stat,
    output logic             o_req_ready,
    output spq_pkg::t_cmd    o_cmd
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_req_ready       = 1'b0;
        o_cmd.load_req    = 1'b0;
        o_cmd.idx_op      = spq_pkg::IDX_HOLD;
        o_cmd.wr_en       = 1'b0;
        o_cmd.wr_addr     = spq_pkg::WA_ZERO;
        o_cmd.wr_src      = spq_pkg::WS_NEW;
        o_cmd.cnt_op      = spq_pkg::CNT_HOLD;
        o_cmd.cap_data    = 1'b0;
        o_cmd.res_load    = 1'b0;
        o_cmd.res_status  = spq_pkg::ST_OK;
        o_cmd.res_src     = spq_pkg::RS_ZERO;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                o_req_ready = i_stat.out_free;
                if (i_req_valid && i_stat.out_free) begin
                    o_cmd.load_req = 1'b1;
                    if (i_req_opcode == spq_pkg::OP_INSERT) begin
                        if (i_stat.cnt_full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = spq_pkg::ST_FULL;
                        end else if (i_stat.cnt_zero) begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.wr_addr  = spq_pkg::WA_ZERO;
                            o_cmd.wr_src   = spq_pkg::WS_NEW;
                            o_cmd.cnt_op   = spq_pkg::CNT_INC;
                            o_cmd.res_load = 1'b1;
                        end else begin
                            o_cmd.idx_op = spq_pkg::IDX_TOP;
                            n_state      = spq_pkg::S_INS;
                        end
                    end else begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = spq_pkg::ST_NONE;
                        end else begin
                            o_cmd.idx_op = spq_pkg::IDX_ZERO;
                            n_state      = spq_pkg::S_FIND;
                        end
                    end
                end
            end
            spq_pkg::S_INS: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = spq_pkg::WA_UP;
                if (i_stat.ins_shift) begin
                    o_cmd.wr_src = spq_pkg::WS_RDATA;
                    if (i_stat.idx_zero) begin
                        n_state = spq_pkg::S_INS_LAST;
                    end else begin
                        o_cmd.idx_op = spq_pkg::IDX_DEC;
                    end
                end else begin
                    o_cmd.wr_src   = spq_pkg::WS_NEW;
                    o_cmd.cnt_op   = spq_pkg::CNT_INC;
                    o_cmd.res_load = 1'b1;
                    n_state        = spq_pkg::S_IDLE;
                end
            end
            spq_pkg::S_INS_LAST: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_addr  = spq_pkg::WA_ZERO;
                o_cmd.wr_src   = spq_pkg::WS_NEW;
                o_cmd.cnt_op   = spq_pkg::CNT_INC;
                o_cmd.res_load = 1'b1;
                n_state        = spq_pkg::S_IDLE;
            end
            spq_pkg::S_FIND: begin
                if (i_stat.hit) begin
                    if (i_stat.idx_last) begin
                        o_cmd.cnt_op   = spq_pkg::CNT_DEC;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_src  = spq_pkg::RS_RDATA;
                        n_state        = spq_pkg::S_IDLE;
                    end else begin
                        o_cmd.cap_data = 1'b1;
                        o_cmd.idx_op   = spq_pkg::IDX_INC;
                        n_state        = spq_pkg::S_SHIFT;
                    end
                end else if (i_stat.idx_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = spq_pkg::ST_NONE;
                    n_state          = spq_pkg::S_IDLE;
                end else begin
                    o_cmd.idx_op = spq_pkg::IDX_INC;
                end
            end
            spq_pkg::S_SHIFT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = spq_pkg::WA_DOWN;
                o_cmd.wr_src  = spq_pkg::WS_RDATA;
                if (i_stat.idx_last) begin
                    o_cmd.cnt_op   = spq_pkg::CNT_DEC;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = spq_pkg::RS_HELD;
                    n_state        = spq_pkg::S_IDLE;
                end else begin
                    o_cmd.idx_op = spq_pkg::IDX_INC;
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/spq_dpath.sv @@
// entry store, scan index, fill count, request and result registers
`timescale 1ns / 1ps

module spq_dpath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spq_pkg::t_cmd                     i_cmd,
    input  spq_pkg::t_opcode                  i_opcode,
    input  logic signed [spq_pkg::DATA_W-1:0] i_item_data,
    input  logic [spq_pkg::PRIO_W-1:0]        i_key_priority,
    input  logic                              i_out_ready,
    output spq_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    output logic signed [spq_pkg::DATA_W-1:0] o_out_data,
    output spq_pkg::t_status                  o_status
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = spq_pkg::PRIO_W + spq_pkg::DATA_W;

    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           n_idx;
    logic [CNT_W-1:0]           r_cnt;
    spq_pkg::t_opcode           r_op;
    logic [spq_pkg::PRIO_W-1:0] r_key;
    logic [spq_pkg::DATA_W-1:0] r_data;
    logic [spq_pkg::DATA_W-1:0] r_held;
    logic                       r_out_valid;
    logic [spq_pkg::DATA_W-1:0] r_out_data;
    spq_pkg::t_status           r_out_status;

    logic [IDX_W-1:0]           wr_addr;
    logic [WORD_W-1:0]          wr_word;
    logic [WORD_W-1:0]          rd_word;
    logic [spq_pkg::PRIO_W-1:0] rd_prio;
    logic [spq_pkg::DATA_W-1:0] rd_data;
    logic [spq_pkg::PRIO_W-1:0] new_prio;
    logic [spq_pkg::DATA_W-1:0] new_data;

    assign rd_prio  = rd_word[WORD_W-1:spq_pkg::DATA_W];
    assign rd_data  = rd_word[spq_pkg::DATA_W-1:0];
    assign new_prio = i_cmd.load_req ? i_key_priority : r_key;
    assign new_data = i_cmd.load_req ? i_item_data : r_data;

    always_comb begin
        case (i_cmd.idx_op)
            spq_pkg::IDX_TOP:  n_idx = IDX_W'(r_cnt - CNT_W'(1));
            spq_pkg::IDX_ZERO: n_idx = '0;
            spq_pkg::IDX_INC:  n_idx = r_idx + IDX_W'(1);
            spq_pkg::IDX_DEC:  n_idx = r_idx - IDX_W'(1);
            default:           n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_addr)
            spq_pkg::WA_UP:   wr_addr = r_idx + IDX_W'(1);
            spq_pkg::WA_DOWN: wr_addr = r_idx - IDX_W'(1);
            default:          wr_addr = '0;
        endcase
        if (i_cmd.wr_src == spq_pkg::WS_RDATA) begin
            wr_word = rd_word;
        end else begin
            wr_word = {new_prio, new_data};
        end
    end

    spq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_word),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.cnt_op)
                spq_pkg::CNT_INC: r_cnt <= r_cnt + CNT_W'(1);
                spq_pkg::CNT_DEC: r_cnt <= r_cnt - CNT_W'(1);
                default:          r_cnt <= r_cnt;
            endcase
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_req) begin
            r_op   <= i_opcode;
            r_key  <= i_key_priority;
            r_data <= i_item_data;
        end
        if (i_cmd.cap_data) begin
            r_held <= rd_data;
        end
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_status;
            case (i_cmd.res_src)
                spq_pkg::RS_HELD:  r_out_data <= r_held;
                spq_pkg::RS_RDATA: r_out_data <= rd_data;
                default:           r_out_data <= '0;
            endcase
        end
    end

    always_comb begin
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.cnt_full  = (r_cnt == CNT_W'(DEPTH));
        o_stat.idx_zero  = (r_idx == '0);
        o_stat.idx_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);
        o_stat.ins_shift = (rd_prio > r_key);
        o_stat.out_free  = !r_out_valid || i_out_ready;
        case (r_op)
            spq_pkg::OP_EXACT:   o_stat.hit = (rd_prio == r_key);
            spq_pkg::OP_ATLEAST: o_stat.hit = (rd_prio >= r_key);
            default:             o_stat.hit = 1'b1;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_status    = r_out_status;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// sorted priority queue top level
// Holds up to DEPTH (data, priority) entries in one memory, sorted by ascending
// priority number, equal priorities in arrival order. One request is worked at a
// time; the result sits in an output register, and the next request is taken once
// that register is empty or being emptied. The memory moves one entry per cycle
// (one read and one write). A refused insert, an insert into an empty queue and
// any extract from an empty queue finish in the accept cycle; any other insert
// moves each entry of higher priority number up by one, and an extract walks
// every entry whether or not one matches. No clearing pass is needed after reset,
// since only entries below the fill count are read.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_req_if.sink    i_req,
    spq_res_if.source  o_res
);

    spq_pkg::t_cmd    cmd;
    spq_pkg::t_stat   stat;
    spq_pkg::t_status res_status;

    spq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_opcode (spq_pkg::t_opcode'(i_req.opcode)),
        .i_stat       (stat),
        .o_req_ready  (i_req.ready),
        .o_cmd        (cmd)
    );

    spq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (spq_pkg::t_opcode'(i_req.opcode)),
        .i_item_data    (i_req.item_data),
        .i_key_priority (i_req.key_priority),
        .i_out_ready    (o_res.ready),
        .o_stat         (stat),
        .o_out_valid    (o_res.valid),
        .o_out_data     (o_res.out_data),
        .o_status       (res_status)
    );

    assign o_res.status = res_status;

endmodule

@@ hw/rtl/spq_checker.sv @@
// port-level checker for the sorted priority queue, bound to the top level
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"

module spq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_ready,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [spq_pkg::DATA_W-1:0] i_res_data,
    input logic [spq_pkg::ST_W-1:0]   i_res_status
);

    logic                                     res_stalled;
    logic [spq_pkg::DATA_W+spq_pkg::ST_W-1:0] res_word;
    logic                                     status_legal;
    logic                                     res_failed;

    assign res_stalled  = i_res_valid && !i_res_ready;
    assign res_word     = {i_res_data, i_res_status};
    assign status_legal = (i_res_status == spq_pkg::ST_OK)
                       || (i_res_status == spq_pkg::ST_FULL)
                       || (i_res_status == spq_pkg::ST_NONE);
    assign res_failed   = i_res_valid && (i_res_status != spq_pkg::ST_OK);

    // a stalled result holds its payload
    `SPQ_ASSERT_NEXT(a_res_hold, res_stalled, i_res_valid && $stable(res_word))

    // only defined status codes leave the block
    `SPQ_ASSERT_IMPL(a_status_legal, i_res_valid, status_legal)

    // a failed request returns no data
    `SPQ_ASSERT_IMPL(a_fail_zero, res_failed, i_res_data == '0)

    // no new request while an untaken result waits
    `SPQ_ASSERT_IMPL(a_req_backpressure, res_stalled, !i_req_ready)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_data   (o_res.out_data),
    .i_res_status (o_res.status)
);

@@ verif/tb.sv @@
// self-checking testbench for the sorted priority queue
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spq_req_if req_ch ();
    spq_res_if res_ch ();

    sorted_priority_queue #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    logic signed [DATA_W-1:0] shadow_data [DEPTH];
    logic [PRIO_W-1:0]        shadow_prio [DEPTH];
    int                       shadow_fill;

    t_outcome pending_results [$];
    t_outcome want;
    int       fail_count;
    bit       tx_calm;
    bit       rx_calm;
    int       hold_off_len;

    // sorted insert, head / exact / at-least removal with gap closing
    function automatic t_outcome pq_apply(t_opcode op, logic signed [DATA_W-1:0] data,
                                          logic [PRIO_W-1:0] key);
        t_outcome r;
        int pos;
        int j;
        r.data = '0;
        r.status = ST_NONE;
        pos = -1;
        case (op)
            OP_INSERT: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    j = shadow_fill;
                    while (j > 0 && shadow_prio[j-1] > key) begin
                        shadow_data[j] = shadow_data[j-1];
                        shadow_prio[j] = shadow_prio[j-1];
                        j--;
                    end
                    shadow_data[j] = data;
                    shadow_prio[j] = key;
                    shadow_fill++;
                    r.status = ST_OK;
                end
            end
            OP_HEAD: begin
                if (shadow_fill > 0) pos = 0;
            end
            default: begin
                for (j = 0; j < shadow_fill; j++) begin
                    if (pos < 0 && ((op == OP_EXACT) ? (shadow_prio[j] == key)
                                                     : (shadow_prio[j] >= key)))
                        pos = j;
                end
            end
        endcase
        if (pos >= 0) begin
            r.data = shadow_data[pos];
            for (j = pos; j < shadow_fill - 1; j++) begin
                shadow_data[j] = shadow_data[j+1];
                shadow_prio[j] = shadow_prio[j+1];
            end
            shadow_fill--;
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic int pick_gap(bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PRIO_W-1:0] pick_key(int kind, logic [PRIO_W-1:0] base);
        logic [PRIO_W-1:0] k;
        case (kind)
            0: k = base + PRIO_W'($urandom_range(0, 7));
            1: k = base + PRIO_W'($urandom_range(0, 255));
            2: k = PRIO_W'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0: k = '0;
                    1: k = '1;
                    2: k = PRIO_W'(1);
                    default: k = {PRIO_W{1'b1}} - PRIO_W'(1);
                endcase
            end
        endcase
        return k;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(t_opcode op, logic signed [DATA_W-1:0] data,
                            logic [PRIO_W-1:0] key);
        int gap;
        gap = pick_gap(tx_calm);
        repeat (gap) begin
            req_ch.valid        = 1'b0;
            req_ch.opcode       = OP_W'($urandom);
            req_ch.item_data    = $urandom;
            req_ch.key_priority = PRIO_W'($urandom);
            @(negedge i_clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.opcode       = op;
        req_ch.item_data    = data;
        req_ch.key_priority = key;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(pq_apply(op, data, key));
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_req(OP_HEAD, 32'sd0, 16'd0);
        send_req(OP_EXACT, 32'sd0, 16'd0);
        send_req(OP_ATLEAST, 32'sd0, 16'd0);
        send_req(OP_INSERT, 32'sh8000_0000, 16'hffff);
        send_req(OP_INSERT, 32'sh7fff_ffff, 16'h0000);
        send_req(OP_INSERT, -32'sd1, 16'd100);
        send_req(OP_INSERT, 32'sd1, 16'd100);
        send_req(OP_INSERT, 32'sd2, 16'd100);
        send_req(OP_EXACT, 32'sd0, 16'd100);
        send_req(OP_EXACT, 32'sd0, 16'd5);
        send_req(OP_ATLEAST, 32'sd0, 16'd101);
        send_req(OP_ATLEAST, 32'sd0, 16'hffff);
        send_req(OP_ATLEAST, 32'sd0, 16'd0);
        send_req(OP_HEAD, 32'sd0, 16'd0);
        send_req(OP_HEAD, 32'sd0, 16'd0);
        send_req(OP_HEAD, 32'sd0, 16'd0);
        send_req(OP_INSERT, 32'sh5555_5555, 16'hffff);
        send_req(OP_INSERT, 32'shaaaa_aaaa, 16'h0000);
        send_req(OP_EXACT, 32'sd0, 16'hffff);
        send_req(OP_EXACT, 32'sd0, 16'h0000);
    endtask

    // fill past capacity with colliding priorities, then drain past empty
    task automatic test_full_queue();
        int k;
        for (k = 0; k < DEPTH + 2; k++)
            send_req(OP_INSERT, $urandom, PRIO_W'($urandom_range(0, 3)));
        for (k = 0; k < DEPTH + 1; k++)
            send_req(OP_HEAD, $urandom, PRIO_W'($urandom));
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        int k;
        tx_calm = 1'b1;
        hold_off_len = 250;
        for (k = 0; k < 20; k++) begin
            if (k < 12)
                send_req(OP_INSERT, $urandom, PRIO_W'($urandom_range(0, 15)));
            else
                send_req(t_opcode'($urandom_range(1, 3)), $urandom,
                         PRIO_W'($urandom_range(0, 15)));
        end
        tx_calm = 1'b0;
    endtask

    task automatic test_random_mix(int n_items);
        int done;
        int seg;
        int k;
        int thr;
        int kind;
        logic [PRIO_W-1:0] base;
        logic [PRIO_W-1:0] key;
        t_opcode op;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(0, 2))
                0: thr = 75;
                1: thr = 30;
                default: thr = 50;
            endcase
            kind = $urandom_range(0, 3);
            base = PRIO_W'($urandom);
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            seg = $urandom_range(10, 40);
            for (k = 0; k < seg && done < n_items; k++) begin
                if ($urandom_range(0, 99) < thr)
                    op = OP_INSERT;
                else
                    op = t_opcode'($urandom_range(1, 3));
                key = pick_key(kind, base);
                if (op == OP_EXACT && shadow_fill > 0 && $urandom_range(0, 9) < 6)
                    key = shadow_prio[$urandom_range(0, shadow_fill - 1)];
                if (op == OP_ATLEAST && shadow_fill > 0 && $urandom_range(0, 9) < 5)
                    key = shadow_prio[$urandom_range(0, shadow_fill - 1)]
                          + PRIO_W'($urandom_range(0, 1));
                send_req(op, $urandom, key);
                done++;
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_off_len > 0) begin
                stall = hold_off_len;
                hold_off_len = 0;
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
                stall = pick_gap(1'b0) + 1;
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end else begin
                res_ch.ready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: out_data %0d status %0d",
                       res_ch.out_data, res_ch.status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.out_data !== want.data) begin
                    $error("out_data mismatch: expected %0d, got %0d",
                           want.data, res_ch.out_data);
                    fail_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, res_ch.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        fail_count          = 0;
        tx_calm             = 1'b0;
        rx_calm             = 1'b0;
        hold_off_len        = 0;
        shadow_fill         = 0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = '0;
        req_ch.item_data    = '0;
        req_ch.key_priority = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_queue();
        test_backpressure();
        test_random_mix(575);

        req_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * DEPTH) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
